// ----- src/wes_pkg.sv -----
// Shared types, constants and helpers for the weekly event scheduler table.
package wes_pkg;

  localparam int LIGHT_W     = 8;
  localparam int LB_W        = LIGHT_W + 1;
  localparam int MIN_W       = 11;
  localparam int DAY_W       = 4;
  localparam int TODAY_W     = 3;
  localparam int OUT_LIGHT_W = 5;

  typedef enum logic [1:0] {
    OP_SCHED_ON  = 2'd0,
    OP_SCHED_OFF = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_TICK      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic [DAY_W-1:0] DAY_EVERY    = 4'd7;
  localparam logic [DAY_W-1:0] DAY_WEEKDAYS = 4'd8;
  localparam logic [DAY_W-1:0] DAY_WEEKEND  = 4'd9;

  localparam logic [TODAY_W-1:0] DOW_SUNDAY   = 3'd0;
  localparam logic [TODAY_W-1:0] DOW_MONDAY   = 3'd1;
  localparam logic [TODAY_W-1:0] DOW_FRIDAY   = 3'd5;
  localparam logic [TODAY_W-1:0] DOW_SATURDAY = 3'd6;

  typedef struct packed {
    opcode_t             opcode;
    logic [LIGHT_W-1:0]  light_id;
    logic [DAY_W-1:0]    day_code;
    logic [MIN_W-1:0]    minute_of_day;
    logic [TODAY_W-1:0]  today;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic                   fired;
    logic [OUT_LIGHT_W-1:0] out_light;
    logic                   turn_on;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] light;
    logic [MIN_W-1:0]   minute;
    logic               on;
    logic [DAY_W-1:0]   day;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    step;
    logic    write_entry;
    logic    clear_entry;
    logic    set_status;
    status_t new_status;
    logic    take_hit;
    logic    push;
    logic    flush;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    hit;
    logic    at_end;
    logic    light_bad;
    logic    out_free;
    logic    pend_fired;
  } dp_stat_t;

  // Day codes 10..15 never match; a today of 7 matches only every-day.
  function automatic logic day_match(input logic [DAY_W-1:0] code,
                                     input logic [TODAY_W-1:0] today);
    logic m;
    m = 1'b0;
    if (code == DAY_EVERY) begin
      m = 1'b1;
    end else if (code < DAY_EVERY) begin
      m = (code[TODAY_W-1:0] == today);
    end else if (code == DAY_WEEKEND) begin
      m = (today == DOW_SUNDAY) || (today == DOW_SATURDAY);
    end else if (code == DAY_WEEKDAYS) begin
      m = (today >= DOW_MONDAY) && (today <= DOW_FRIDAY);
    end
    return m;
  endfunction

endpackage

// ----- src/wes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wes_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/wes_dp.sv -----
// Datapath: item register, scan index, valid bits, event RAM, result registers.
module wes_dp import wes_pkg::*; #(
  parameter int EVENTS = 64,
  parameter int LIGHTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1;

  in_item_t           item;
  logic [IDX_W-1:0]   idx;
  logic [EVENTS-1:0]  valid;
  out_item_t          pend;
  entry_t             cur;
  entry_t             wentry;
  logic [$bits(entry_t)-1:0] rdata;
  logic               v_here;
  logic               rm_hit;
  logic               tick_hit;
  logic               out_free;

  assign wentry.light  = item.light_id;
  assign wentry.minute = item.minute_of_day;
  assign wentry.on     = (item.opcode == OP_SCHED_ON);
  assign wentry.day    = item.day_code;

  wes_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (EVENTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write_entry),
    .waddr (idx),
    .wdata (wentry),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (rdata)
  );

  assign cur    = entry_t'(rdata);
  assign v_here = valid[idx];

  assign rm_hit = v_here && (cur.light == item.light_id) &&
                  (cur.minute == item.minute_of_day) && (cur.day == item.day_code);
  assign tick_hit = v_here && day_match(cur.day, item.today) &&
                    (cur.minute == item.minute_of_day);

  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat.op         = item.opcode;
    stat.at_end     = (idx == IDX_W'(EVENTS - 1));
    stat.light_bad  = ({1'b0, item.light_id} >= LB_W'(LIGHTS));
    stat.out_free   = out_free;
    stat.pend_fired = pend.fired;
    case (item.opcode)
      OP_SCHED_ON, OP_SCHED_OFF: stat.hit = !v_here;
      OP_REMOVE:                 stat.hit = rm_hit;
      OP_TICK:                   stat.hit = tick_hit;
      default:                   stat.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.write_entry) begin
      valid[idx] <= 1'b1;
    end else if (cmd.clear_entry) begin
      valid[idx] <= 1'b0;
    end
  end

  // pend.fired doubles as "a tick result is held"
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend <= '{status: ST_OK, fired: 1'b0, out_light: '0, turn_on: 1'b0, last: 1'b0};
    end else if (cmd.take_hit) begin
      pend <= '{status: ST_OK, fired: 1'b1, out_light: cur.light[OUT_LIGHT_W-1:0],
                turn_on: cur.on, last: 1'b0};
    end else if (cmd.set_status) begin
      pend.status <= cmd.new_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.flush) begin
      out_data <= '{status: pend.status, fired: pend.fired, out_light: pend.out_light,
                    turn_on: pend.turn_on, last: cmd.flush};
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.push || cmd.flush) |-> out_free)
    else $error("result loaded while output register busy");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write_entry |-> !valid[idx])
    else $error("schedule overwrote a live entry");

  a_clear_live: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_entry |=> !$past(valid[idx]) == 1'b0)
    else $error("remove cleared a free entry");

endmodule

// ----- src/wes_ctrl.sv -----
// Controller: sequences the table scan for schedule, remove and tick items.
module wes_ctrl import wes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        case (stat.op)
          OP_SCHED_ON, OP_SCHED_OFF: begin
            if (stat.light_bad) begin
              cmd.set_status = 1'b1;
              cmd.new_status = ST_BAD_ID;
              state_next     = S_FLUSH;
            end else if (stat.hit) begin
              cmd.write_entry = 1'b1;
              state_next      = S_FLUSH;
            end else if (stat.at_end) begin
              cmd.set_status = 1'b1;
              cmd.new_status = ST_FULL;
              state_next     = S_FLUSH;
            end else begin
              cmd.step   = 1'b1;
              state_next = S_READ;
            end
          end
          OP_REMOVE: begin
            if (stat.hit) begin
              cmd.clear_entry = 1'b1;
              state_next      = S_FLUSH;
            end else if (stat.at_end) begin
              state_next = S_FLUSH;
            end else begin
              cmd.step   = 1'b1;
              state_next = S_READ;
            end
          end
          OP_TICK: begin
            // a new hit pushes out the held one; hold here if that push finds the output busy
            if (!(stat.hit && stat.pend_fired && !stat.out_free)) begin
              cmd.push     = stat.hit && stat.pend_fired;
              cmd.take_hit = stat.hit;
              if (stat.at_end) begin
                state_next = S_FLUSH;
              end else begin
                cmd.step   = 1'b1;
                state_next = S_READ;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/weekly_event_scheduler_table_top.sv -----
// Top level of the weekly event scheduler table.
//
//   channel | signals                        | payload
//   input   | in_valid / in_ready / in_data   | in_item_t
//   output  | out_valid / out_ready / out_data| out_item_t
//
// Every item scans the table one entry at a time: a RAM read state, then a check.
// A tick scans every entry, then flushes: its final result, marked last, is
// loaded from the flush state, and the next item is accepted back in idle.
// Schedule and remove stop at the hit. in_ready is high only between items.
// A result waits in the output register; the scan holds when another is due.
// Reset clears all entry valid bits at once; the event RAM is not cleared.
module weekly_event_scheduler_table_top import wes_pkg::*; #(
  parameter int EVENTS = 64,
  parameter int LIGHTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  wes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wes_dp #(
    .EVENTS (EVENTS),
    .LIGHTS (LIGHTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
